// File: design/hse_pkg.sv
// Package for the heap sort engine: sizes, storage types, and the command
// and status structs that join the controller to the datapath.
// Depends on nothing; the datapath, the controller and the top import it.
package hse_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IO_WIDTH   = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CHILD_W    = ADDR_W + 2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CHILD_W-1:0]    child_t;

  // Commands from the controller, at most one step command per cycle.
  typedef struct packed {
    logic accept;
    logic start;
    logic build_ld;
    logic sift_fx;
    logic sift;
    logic ext_init;
    logic swap_ld;
    logic swap_fx;
    logic emit_rd;
    logic emit_ld;
  } cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic kc_zero;
    logic kc_gt1;
    logic sift_done;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

// File: design/hse_ram.sv
// Generic memory with one write port and two registered read ports.
// Depends on nothing; the heap store is one instance of it.
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/hse_datapath.sv
// Datapath of the heap sort engine: heap store, counters, sift compare
// logic and the output register. Depends on hse_pkg and hse_ram.
module hse_datapath
  import hse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [IO_WIDTH-1:0] in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IO_WIDTH-1:0] out_value,
  output logic                out_last,
  output logic                out_overflow
);

  // True when a belongs above b in the heap of the current mode.
  function automatic logic above(data_t a, data_t b, logic asc);
    return asc ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

  logic  ascending;
  cnt_t  count;
  logic  dropped;
  cnt_t  kc;
  cnt_t  size;
  cnt_t  ei;
  addr_t node;
  data_t x;

  logic  we;
  addr_t waddr;
  data_t wdata;
  addr_t raddr_a;
  addr_t raddr_b;
  data_t rdata_a;
  data_t rdata_b;

  cnt_t   kc_m1;
  logic   has_room;
  addr_t  base;
  child_t lc;
  child_t rc;
  child_t node_lc;
  child_t node_rc;
  logic   take_l;
  logic   take_r;
  data_t  bv1;
  data_t  bv;
  addr_t  best1;
  addr_t  best;

  hse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign kc_m1    = kc - cnt_t'(1);
  assign has_room = count < cnt_t'(DEPTH);

  // One level of sift-down: the sifting value x waits in a register, the
  // two children come from the memory read ports.
  assign node_lc = {1'b0, node, 1'b1};
  assign node_rc = node_lc + child_t'(1);
  assign take_l  = (node_lc < child_t'(size)) && above(rdata_a, x, ascending);
  assign bv1     = take_l ? rdata_a : x;
  assign best1   = take_l ? node_lc[ADDR_W-1:0] : node;
  assign take_r  = (node_rc < child_t'(size)) && above(rdata_b, bv1, ascending);
  assign bv      = take_r ? rdata_b : bv1;
  assign best    = take_r ? node_rc[ADDR_W-1:0] : best1;

  // Node whose children are fetched next.
  always_comb begin
    base = node;
    if (cmd.swap_fx) begin
      base = '0;
    end else if (cmd.sift) begin
      base = best;
    end
  end

  assign lc = {1'b0, base, 1'b1};
  assign rc = lc + child_t'(1);

  always_comb begin
    we    = 1'b0;
    waddr = count[ADDR_W-1:0];
    wdata = DATA_WIDTH'(signed'(in_value));
    if (cmd.accept) begin
      we = has_room;
    end else if (cmd.swap_fx) begin
      we    = 1'b1;
      waddr = kc_m1[ADDR_W-1:0];
      wdata = rdata_a;
    end else if (cmd.sift) begin
      we    = 1'b1;
      waddr = node;
      wdata = sts.sift_done ? x : bv;
    end
  end

  always_comb begin
    raddr_a = lc[ADDR_W-1:0];
    raddr_b = rc[ADDR_W-1:0];
    if (cmd.build_ld) begin
      raddr_a = kc_m1[ADDR_W-1:0];
    end else if (cmd.swap_ld) begin
      raddr_a = '0;
      raddr_b = kc_m1[ADDR_W-1:0];
    end else if (cmd.emit_rd) begin
      raddr_a = ei[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ascending <= 1'b1;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ascending <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (has_room) begin
          count <= count + cnt_t'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.emit_ld && sts.emit_last) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kc   <= count >> 1;
      size <= count;
    end else if (cmd.build_ld) begin
      kc   <= kc_m1;
      node <= kc_m1[ADDR_W-1:0];
    end else if (cmd.ext_init) begin
      kc <= count;
      ei <= '0;
    end else if (cmd.swap_fx) begin
      kc   <= kc_m1;
      size <= kc_m1;
      node <= '0;
      x    <= rdata_b;
    end else if (cmd.sift_fx) begin
      x <= rdata_a;
    end else if (cmd.sift) begin
      node <= best;
    end else if (cmd.emit_ld) begin
      ei           <= ei + cnt_t'(1);
      out_value    <= IO_WIDTH'(rdata_a);
      out_last     <= sts.emit_last;
      out_overflow <= dropped;
    end
  end

  assign sts.kc_zero   = (kc == '0);
  assign sts.kc_gt1    = (kc > cnt_t'(1));
  assign sts.sift_done = !take_l && !take_r;
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.emit_last = ((ei + cnt_t'(1)) == count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(DEPTH))
    else $error("item count exceeds store depth");

  a_sift_descends: assert property (@(posedge clk) disable iff (rst)
    cmd.sift && !sts.sift_done |=> node > $past(node))
    else $error("sift step did not move down the heap");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld |-> !out_valid)
    else $error("output register overwritten before it was taken");

endmodule

// File: design/hse_ctrl.sv
// Controller of the heap sort engine: one-hot state machine that sequences
// loading, heap build, extraction and emission. Depends on hse_pkg.
module hse_ctrl
  import hse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_START = 12'b0000_0000_0010,
    S_BCHK  = 12'b0000_0000_0100,
    S_BLD   = 12'b0000_0000_1000,
    S_SFX   = 12'b0000_0001_0000,
    S_SIFT  = 12'b0000_0010_0000,
    S_XINIT = 12'b0000_0100_0000,
    S_XCHK  = 12'b0000_1000_0000,
    S_SWLD  = 12'b0001_0000_0000,
    S_SWFX  = 12'b0010_0000_0000,
    S_ERD   = 12'b0100_0000_0000,
    S_ELD   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   extract_phase;
  logic   extract_phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next         = state;
    extract_phase_next = extract_phase;
    cmd                = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start          = 1'b1;
        extract_phase_next = 1'b0;
        state_next         = S_BCHK;
      end
      S_BCHK: begin
        state_next = sts.kc_zero ? S_XINIT : S_BLD;
      end
      S_BLD: begin
        cmd.build_ld = 1'b1;
        state_next   = S_SFX;
      end
      S_SFX: begin
        cmd.sift_fx = 1'b1;
        state_next  = S_SIFT;
      end
      S_SIFT: begin
        cmd.sift = 1'b1;
        if (sts.sift_done) begin
          state_next = extract_phase ? S_XCHK : S_BCHK;
        end
      end
      S_XINIT: begin
        cmd.ext_init       = 1'b1;
        extract_phase_next = 1'b1;
        state_next         = S_XCHK;
      end
      S_XCHK: begin
        state_next = sts.kc_gt1 ? S_SWLD : S_ERD;
      end
      S_SWLD: begin
        cmd.swap_ld = 1'b1;
        state_next  = S_SWFX;
      end
      S_SWFX: begin
        cmd.swap_fx = 1'b1;
        state_next  = S_SIFT;
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        if (sts.out_free) begin
          state_next = S_ELD;
        end
      end
      S_ELD: begin
        cmd.emit_ld = 1'b1;
        state_next  = sts.emit_last ? S_IDLE : S_ERD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      extract_phase <= 1'b0;
    end else begin
      state         <= state_next;
      extract_phase <= extract_phase_next;
    end
  end

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> state == S_START)
    else $error("final beat did not start the sort");

  a_sift_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_SIFT && !sts.sift_done |=> state == S_SIFT)
    else $error("sift left before the value settled");

endmodule

// File: design/heap_sort_engine.sv
// Heap sort engine: loads one beat per cycle while idle, sorts on the marked last beat.
// Sort of n items: each build node passes BCHK, BLD and SFX and each extraction
// XCHK, SWLD and SWFX, then sifts one heap node per SIFT step (levels walked
// plus one); each sorted beat then passes ERD, waiting for a free output, and ELD.
// Synchronous active-high rst clears the count, the drop flag, the output
// valid and sets ascending mode; the heap store keeps its contents.
module heap_sort_engine
  import hse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration: bit 0 of cfg_wdata is the ascending flag.
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IO_WIDTH-1:0] s_axis_tdata,  // [31:0] value
  input  logic                s_axis_tlast,  // last
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [IO_WIDTH-1:0] m_axis_tdata,  // [31:0] value_res
  output logic                m_axis_tlast,  // last_res
  output logic                m_axis_tuser   // [0] overflow
);

  // The controller owns sequencing; the datapath owns all storage and the
  // compare logic. A beat is loaded only while the controller is idle, but
  // the output register is separate, so a new set may start loading while
  // the final sorted beat of the previous set is still waiting.
  cmd_t cmd;
  sts_t sts;

  hse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Values beyond the store's capacity are dropped; the overflow bit then
  // rides on every sorted beat of that set.
  hse_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (s_axis_tdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_value    (m_axis_tdata),
    .out_last     (m_axis_tlast),
    .out_overflow (m_axis_tuser)
  );

endmodule
